// File: rtl/anls_pkg.sv
`default_nettype none

package anls_pkg;

    // Unit length counter: width follows LENGTH_WIDTH, capped at 32 bits.
    localparam int LENGTH_WIDTH = 32;
    localparam int CNT_W        = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;
    localparam int UNIT_W       = 32;
    localparam int MAXU_W       = 16;
    localparam int BYTE_W       = 8;

    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;

    localparam logic [1:0] ZRUN_SAT = 2'd3;

    // Register map, indexed by paddr[2]
    localparam int          APB_AW        = 3;
    localparam logic        REG_MAX_UNITS = 1'b0;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [UNIT_W-1:0] unit_bytes;
        logic              unit_valid;
        logic              last_result;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic report_ok(
        input logic              in_unit,
        input logic              ovf,
        input logic              long_sc,
        input logic [CNT_W-1:0]  len,
        input logic [MAXU_W-1:0] max_u,
        input logic [MAXU_W-1:0] reported
    );
        logic [CNT_W-1:0] sc_len;
        logic             capped;
        sc_len = long_sc ? CNT_W'(4) : CNT_W'(3);
        capped = (max_u != '0) && (reported >= max_u);
        return in_unit && !ovf && (len > sc_len) && !capped;
    endfunction

endpackage

`default_nettype wire

// File: rtl/anls_cfg.sv
`default_nettype none

module anls_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [anls_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic [anls_pkg::MAXU_W-1:0]      max_units
);

    logic [anls_pkg::MAXU_W-1:0] max_units_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg <= '0;
        end
        else if (wr_en && (paddr[2] == anls_pkg::REG_MAX_UNITS))
        begin
            max_units_reg <= pwdata[anls_pkg::MAXU_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            anls_pkg::REG_MAX_UNITS: prdata = 32'(max_units_reg);
            default:                 prdata = '0;
        endcase
    end

    assign max_units = max_units_reg;

endmodule

`default_nettype wire

// File: rtl/anls_core.sv
`default_nettype none

module anls_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [anls_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        stream_end,
    input  wire logic [anls_pkg::MAXU_W-1:0] max_units,
    output anls_pkg::push_t                  push
);

    logic [1:0]                  zrun_reg,   zrun_next;
    logic                        inunit_reg, inunit_next;
    logic [anls_pkg::CNT_W-1:0]  cnt_reg,    cnt_next;
    logic                        lsc_reg,    lsc_next;
    logic                        ovf_reg,    ovf_next;
    logic [anls_pkg::MAXU_W-1:0] rep_reg,    rep_next;

    logic                        is_zero;
    logic                        is_sc;
    logic [anls_pkg::CNT_W-1:0]  base;
    logic                        ovf_base;
    logic [2:0]                  add_k;
    logic [anls_pkg::CNT_W:0]    sum;
    logic                        carry;
    logic                        rep1_ok;
    logic                        rep2_ok;
    logic [anls_pkg::MAXU_W-1:0] rep_after1;
    anls_pkg::res_t              res1;
    anls_pkg::res_t              res2;

    always_comb
    begin
        is_zero     = (data_byte == anls_pkg::BYTE_ZERO);
        is_sc       = (data_byte == anls_pkg::BYTE_ONE) && (zrun_reg >= 2'd2);
        zrun_next   = zrun_reg;
        inunit_next = inunit_reg;
        lsc_next    = lsc_reg;
        base        = cnt_reg;
        ovf_base    = ovf_reg;
        add_k       = '0;
        rep1_ok     = 1'b0;

        if (is_zero)
        begin
            zrun_next = (zrun_reg == anls_pkg::ZRUN_SAT) ? anls_pkg::ZRUN_SAT
                                                         : zrun_reg + 2'd1;
            if (inunit_reg)
            begin
                add_k = ((zrun_reg == anls_pkg::ZRUN_SAT) ? 3'd1 : 3'd0)
                      + (stream_end ? {1'b0, zrun_next} : 3'd0);
            end
        end
        else if (is_sc)
        begin
            rep1_ok     = anls_pkg::report_ok(inunit_reg, ovf_reg, lsc_reg, cnt_reg,
                                              max_units, rep_reg);
            inunit_next = 1'b1;
            lsc_next    = (zrun_reg == anls_pkg::ZRUN_SAT);
            base        = anls_pkg::CNT_W'(zrun_reg) + anls_pkg::CNT_W'(1);
            ovf_base    = 1'b0;
            zrun_next   = '0;
        end
        else
        begin
            if (inunit_reg)
            begin
                add_k = {1'b0, zrun_reg} + 3'd1;
            end
            zrun_next = '0;
        end

        // one saturating add covers the byte and the closing zeros
        sum      = {1'b0, base} + (anls_pkg::CNT_W + 1)'(add_k);
        carry    = sum[anls_pkg::CNT_W];
        cnt_next = carry ? '1 : sum[anls_pkg::CNT_W-1:0];
        ovf_next = ovf_base | carry;

        rep_after1 = (rep1_ok && (rep_reg != '1)) ? rep_reg + 1'b1 : rep_reg;
        rep_next   = rep_after1;
        rep2_ok    = anls_pkg::report_ok(inunit_next, ovf_next, lsc_next, cnt_next,
                                         max_units, rep_after1);

        res1.unit_bytes  = anls_pkg::UNIT_W'(cnt_reg);
        res1.unit_valid  = 1'b1;
        res1.last_result = 1'b0;
        res2.unit_bytes  = rep2_ok ? anls_pkg::UNIT_W'(cnt_next) : '0;
        res2.unit_valid  = rep2_ok;
        res2.last_result = 1'b1;

        push.count  = accept ? ({1'b0, rep1_ok} + {1'b0, stream_end}) : 2'd0;
        push.first  = rep1_ok ? res1 : res2;
        push.second = res2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zrun_reg   <= '0;
            inunit_reg <= 1'b0;
            cnt_reg    <= '0;
            lsc_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            rep_reg    <= '0;
        end
        else if (accept)
        begin
            if (stream_end)
            begin
                zrun_reg   <= '0;
                inunit_reg <= 1'b0;
                cnt_reg    <= '0;
                lsc_reg    <= 1'b0;
                ovf_reg    <= 1'b0;
                rep_reg    <= '0;
            end
            else
            begin
                zrun_reg   <= zrun_next;
                inunit_reg <= inunit_next;
                cnt_reg    <= cnt_next;
                lsc_reg    <= lsc_next;
                ovf_reg    <= ovf_next;
                rep_reg    <= rep_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/anls_outq.sv
`default_nettype none

module anls_outq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire anls_pkg::push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output anls_pkg::res_t       out_res
);

    anls_pkg::res_t              entry_reg [anls_pkg::QDEPTH];
    logic [anls_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [anls_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [anls_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [anls_pkg::QPTR_W-1:0] wptr_plus1;
    logic                        pop;

    assign out_valid  = (count_reg != '0);
    assign out_res    = entry_reg[rptr_reg];
    assign pop        = out_valid && out_ready;
    assign room       = (count_reg <= anls_pkg::QCNT_W'(anls_pkg::QDEPTH - 2));
    assign wptr_plus1 = wptr_reg + 1'b1;

    always_comb
    begin
        wptr_next  = wptr_reg + anls_pkg::QPTR_W'(push.count);
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + anls_pkg::QCNT_W'(push.count)
                   - anls_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/annexb_nalu_length_scanner.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte, tlast: stream_end
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: unit_bytes, tuser: unit_valid,
//                                             tlast: last_result
// apb       in   psel&penable, pready=1       reg 0 @ 0x0: max_units
//
// One input byte is taken per cycle while the queue has room; the scan and
// length update settle in the accept cycle and results reach m_axis through
// a registered 4-entry queue. A byte that ends a unit and the stream yields
// two results; s_axis_tready drops while the queue has fewer than two free
// entries, so m_axis stalls back-pressure the input once three items are held.
// rst_n clears scan state, the queue and max_units; no clearing pass.
`default_nettype none

module annexb_nalu_length_scanner (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
    input  wire logic                        s_axis_tlast,  // stream_end
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // [31:0] unit_bytes
    output logic                             m_axis_tuser,  // [0] unit_valid
    output logic                             m_axis_tlast,  // last_result
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [anls_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    logic [anls_pkg::MAXU_W-1:0] max_units;
    logic                        accept;
    logic                        room;
    anls_pkg::push_t             push;
    anls_pkg::res_t              out_res;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    anls_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_units (max_units)
    );

    anls_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .stream_end (s_axis_tlast),
        .max_units  (max_units),
        .push       (push)
    );

    anls_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.unit_bytes;
    assign m_axis_tuser = out_res.unit_valid;
    assign m_axis_tlast = out_res.last_result;

endmodule

`default_nettype wire

// File: rtl/anls_chk.sv
`default_nettype none

module anls_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast,
    input wire logic        pready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // non-unit items carry zero length
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("empty result with nonzero length");

    // a reported unit is longer than its start code
    a_unit_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata > 32'd3)
        else $error("reported unit too short");

    // only closing results may lack a unit
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result that is not closing");

    // with an empty output queue and pready high, input is ready unless a byte is offered
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && pready |-> s_axis_tready || s_axis_tvalid)
        else $error("input blocked with empty queue");

endmodule

bind annexb_nalu_length_scanner anls_chk u_anls_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

`default_nettype wire
